// ===== hdl/b2s_pkg.sv =====
// ----------------------------------------------------------------------------
// b2s_pkg
// shared types, constants and helpers of the streaming BLAKE2s hash core
// ----------------------------------------------------------------------------
`default_nettype none

package b2s_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int BLOCK_WORDS = BLOCK_BYTES / 4;

    localparam logic [2:0] REG_OUT_LEN    = 3'd0;
    localparam logic [2:0] REG_KEY_LEN    = 3'd1;
    localparam logic [2:0] REG_KEY_PART_0 = 3'd2;
    localparam logic [2:0] REG_KEY_PART_1 = 3'd3;
    localparam logic [2:0] REG_KEY_PART_2 = 3'd4;
    localparam logic [2:0] REG_KEY_PART_3 = 3'd5;

    localparam logic [31:0] PARAM_BASE = 32'h0101_0000;

    localparam logic [31:0] IV_TAB [0:7] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [3:0] PERM_TAB [0:9][0:15] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
          4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
        '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
          4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
        '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
          4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
        '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
          4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
        '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
          4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
        '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
          4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
        '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
          4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
        '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
          4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
        '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
          4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
    };

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        last;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic [2:0]  bytes_valid;
        logic        last_word;
        logic        format_error;
    } out_item_t;

    typedef struct packed {
        logic [31:0] va;
        logic [31:0] vb;
        logic [31:0] vc;
        logic [31:0] vd;
        logic [31:0] m;
        logic [1:0]  step;
    } g_in_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
    } g_out_t;

    function automatic logic [31:0] byte_mask(input logic [2:0] nbytes);
        logic [31:0] r;
        case (nbytes)
            3'd0:    r = 32'h0000_0000;
            3'd1:    r = 32'h0000_00FF;
            3'd2:    r = 32'h0000_FFFF;
            3'd3:    r = 32'h00FF_FFFF;
            default: r = 32'hFFFF_FFFF;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] perm(input logic [3:0] round, input logic [3:0] pos);
        logic [3:0] r;
        if (round > 4'd9)
        begin
            r = PERM_TAB[0][pos];
        end
        else
        begin
            r = PERM_TAB[round][pos];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/b2s_buf_ram.sv =====
// ----------------------------------------------------------------------------
// b2s_buf_ram
// 16 x 32 block buffer, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module b2s_buf_ram (
    input  wire logic        clk,
    input  wire logic        we,
    input  wire logic [3:0]  waddr,
    input  wire logic [31:0] wdata,
    input  wire logic [3:0]  raddr,
    output logic      [31:0] rdata
);

    logic [31:0] mem [0:b2s_pkg::BLOCK_WORDS-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/b2s_g_step.sv =====
// ----------------------------------------------------------------------------
// b2s_g_step
// one quarter of the mixing function: one add and one xor-rotate
// ----------------------------------------------------------------------------
`default_nettype none

module b2s_g_step (
    input  wire b2s_pkg::g_in_t  g_in,
    output b2s_pkg::g_out_t      g_out
);

    logic [31:0] sum_ab;
    logic [31:0] sum_cd;
    logic [31:0] xd;
    logic [31:0] xb;

    always_comb
    begin
        sum_ab = g_in.va + g_in.vb + g_in.m;
        sum_cd = g_in.vc + g_in.vd;
        xd     = g_in.vd ^ sum_ab;
        xb     = g_in.vb ^ sum_cd;
        case (g_in.step)
            2'd0:
            begin
                g_out.x = sum_ab;
                g_out.y = {xd[15:0], xd[31:16]};
            end
            2'd1:
            begin
                g_out.x = sum_cd;
                g_out.y = {xb[11:0], xb[31:12]};
            end
            2'd2:
            begin
                g_out.x = sum_ab;
                g_out.y = {xd[7:0], xd[31:8]};
            end
            default:
            begin
                g_out.x = sum_cd;
                g_out.y = {xb[6:0], xb[31:7]};
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/blake2s_stream_hash_core.sv =====
// ----------------------------------------------------------------------------
// blake2s_stream_hash_core
// streaming BLAKE2s hash, optionally keyed, one 32-bit word per transfer
//
// channel  dir  signals                          transfer
// in       in   in_valid in_ready in_data        in_valid & in_ready
// out      out  out_valid out_ready out_data     out_valid & out_ready
// cfg      in   cfg_wen cfg_index cfg_wdata      cfg_wen
//
// a word that fills no full block is written to the block buffer; a word after
// a full block adds a compression, one quarter mix step per cycle through
// the single mixing unit, message words read from the block buffer memory;
// the last word adds zero padding, a final compression and the digest
// words, sent while the output slot is free; keyed messages load the key
// block first; no clearing pass after reset; the output holds while stalled
// ----------------------------------------------------------------------------
`default_nettype none

module blake2s_stream_hash_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire b2s_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output b2s_pkg::out_item_t      out_data,
    input  wire logic               cfg_wen,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [63:0]        cfg_wdata
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_KEY   = 4'd1;
    localparam logic [3:0] ST_CHECK = 4'd2;
    localparam logic [3:0] ST_WRITE = 4'd3;
    localparam logic [3:0] ST_PAD   = 4'd4;
    localparam logic [3:0] ST_CINIT = 4'd5;
    localparam logic [3:0] ST_ROUND = 4'd6;
    localparam logic [3:0] ST_CEND  = 4'd7;
    localparam logic [3:0] ST_EMIT  = 4'd8;

    logic [3:0]  state_reg;
    logic [5:0]  out_len_reg;
    logic [5:0]  key_len_reg;
    logic [63:0] key_part_reg [0:3];
    logic [31:0] cv_reg [0:7];
    logic [31:0] v_reg [0:15];
    logic [63:0] ctr_reg;
    logic [6:0]  fill_reg;
    logic        started_reg;
    logic [5:0]  dlen_reg;
    b2s_pkg::in_item_t item_reg;
    logic [2:0]  n_reg;
    logic [4:0]  cnt_reg;
    logic        final_reg;
    logic [3:0]  round_reg;
    logic [2:0]  g_reg;
    logic [1:0]  step_reg;
    logic [2:0]  emit_idx_reg;
    logic        out_valid_reg;
    b2s_pkg::out_item_t out_data_reg;

    logic        slot_free;
    logic        in_xfer;
    logic [2:0]  in_n;
    logic        in_err;
    logic [5:0]  eff_out_len;
    logic [5:0]  eff_key_len;

    logic        ram_we;
    logic [3:0]  ram_waddr;
    logic [31:0] ram_wdata;
    logic [3:0]  ram_raddr;
    logic [31:0] ram_rdata;

    logic [1:0]  gj;
    logic [3:0]  ia;
    logic [3:0]  ib;
    logic [3:0]  ic;
    logic [3:0]  id;
    logic [2:0]  g_nxt;
    logic [3:0]  round_nxt;
    b2s_pkg::g_in_t  g_in;
    b2s_pkg::g_out_t g_out;

    logic [6:0]  key_rem;
    logic [2:0]  key_bytes;
    logic [31:0] key_word;
    logic [6:0]  fill_sum;
    logic [7:0]  pad_start;
    logic [6:0]  emit_rem;
    logic [2:0]  emit_valid;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && slot_free;
    assign in_xfer   = in_valid && in_ready;
    assign in_n      = (in_data.byte_count > 3'd4) ? 3'd4 : in_data.byte_count;
    assign in_err    = !in_data.last && (in_n < 3'd4);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        eff_out_len = out_len_reg;
        if (out_len_reg == 6'd0)
        begin
            eff_out_len = 6'd1;
        end
        else if (out_len_reg > 6'd32)
        begin
            eff_out_len = 6'd32;
        end
        eff_key_len = (key_len_reg > 6'd32) ? 6'd32 : key_len_reg;
    end

    // key word with bytes past the key length cleared
    always_comb
    begin
        key_rem   = {1'b0, eff_key_len} - {cnt_reg, 2'b00};
        key_bytes = 3'd0;
        if ({1'b0, eff_key_len} > {cnt_reg, 2'b00})
        begin
            key_bytes = (key_rem > 7'd4) ? 3'd4 : key_rem[2:0];
        end
        if (cnt_reg[3] || cnt_reg[4])
        begin
            key_word = 32'h0;
        end
        else if (cnt_reg[0])
        begin
            key_word = key_part_reg[cnt_reg[2:1]][63:32] & b2s_pkg::byte_mask(key_bytes);
        end
        else
        begin
            key_word = key_part_reg[cnt_reg[2:1]][31:0] & b2s_pkg::byte_mask(key_bytes);
        end
    end

    assign fill_sum  = fill_reg + {4'd0, n_reg};
    assign pad_start = ({1'b0, fill_sum} + 8'd3) >> 2;

    always_comb
    begin
        gj = g_reg[1:0];
        ia = {2'b00, gj};
        if (g_reg[2])
        begin
            ib = {2'b01, gj + 2'd1};
            ic = {2'b10, gj + 2'd2};
            id = {2'b11, gj + 2'd3};
        end
        else
        begin
            ib = {2'b01, gj};
            ic = {2'b10, gj};
            id = {2'b11, gj};
        end
        g_nxt     = g_reg + 3'd1;
        round_nxt = (g_reg == 3'd7) ? round_reg + 4'd1 : round_reg;
    end

    always_comb
    begin
        g_in.va   = v_reg[ia];
        g_in.vb   = v_reg[ib];
        g_in.vc   = v_reg[ic];
        g_in.vd   = v_reg[id];
        g_in.m    = ram_rdata;
        g_in.step = step_reg;
    end

    b2s_g_step u_g_step (
        .g_in  (g_in),
        .g_out (g_out)
    );

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cnt_reg[3:0];
        ram_wdata = 32'h0;
        ram_raddr = 4'd0;
        case (state_reg)
            ST_KEY:
            begin
                ram_we    = 1'b1;
                ram_wdata = key_word;
            end
            ST_WRITE:
            begin
                ram_we    = 1'b1;
                ram_waddr = fill_reg[5:2];
                ram_wdata = item_reg.data_word & b2s_pkg::byte_mask(n_reg);
            end
            ST_PAD:
            begin
                ram_we = !cnt_reg[4];
            end
            ST_CINIT:
            begin
                ram_raddr = b2s_pkg::perm(4'd0, 4'd0);
            end
            ST_ROUND:
            begin
                if (step_reg == 2'd1)
                begin
                    ram_raddr = b2s_pkg::perm(round_reg, {g_reg, 1'b1});
                end
                else
                begin
                    ram_raddr = b2s_pkg::perm(round_nxt, {g_nxt, 1'b0});
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    b2s_buf_ram u_buf_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        emit_rem   = {1'b0, dlen_reg} - {2'b00, emit_idx_reg, 2'b00};
        emit_valid = (emit_rem > 7'd4) ? 3'd4 : emit_rem[2:0];
    end

    // working vector, no reset
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CINIT)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= cv_reg[i];
            end
            v_reg[8]  <= b2s_pkg::IV_TAB[0];
            v_reg[9]  <= b2s_pkg::IV_TAB[1];
            v_reg[10] <= b2s_pkg::IV_TAB[2];
            v_reg[11] <= b2s_pkg::IV_TAB[3];
            v_reg[12] <= b2s_pkg::IV_TAB[4] ^ ctr_reg[31:0];
            v_reg[13] <= b2s_pkg::IV_TAB[5] ^ ctr_reg[63:32];
            v_reg[14] <= b2s_pkg::IV_TAB[6] ^ {32{final_reg}};
            v_reg[15] <= b2s_pkg::IV_TAB[7];
        end
        else if (state_reg == ST_ROUND)
        begin
            if (!step_reg[0])
            begin
                v_reg[ia] <= g_out.x;
                v_reg[id] <= g_out.y;
            end
            else
            begin
                v_reg[ic] <= g_out.x;
                v_reg[ib] <= g_out.y;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg <= in_data;
            n_reg    <= in_n;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_len_reg   <= 6'd32;
            key_len_reg   <= 6'd0;
            for (int i = 0; i < 4; i++)
            begin
                key_part_reg[i] <= 64'h0;
            end
            for (int i = 1; i < 8; i++)
            begin
                cv_reg[i] <= b2s_pkg::IV_TAB[i];
            end
            cv_reg[0]     <= b2s_pkg::IV_TAB[0] ^ b2s_pkg::PARAM_BASE ^ 32'd32;
            ctr_reg       <= 64'h0;
            fill_reg      <= 7'd0;
            started_reg   <= 1'b0;
            dlen_reg      <= 6'd32;
            cnt_reg       <= 5'd0;
            final_reg     <= 1'b0;
            round_reg     <= 4'd0;
            g_reg         <= 3'd0;
            step_reg      <= 2'd0;
            emit_idx_reg  <= 3'd0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_index)
                    b2s_pkg::REG_OUT_LEN:    out_len_reg     <= cfg_wdata[5:0];
                    b2s_pkg::REG_KEY_LEN:    key_len_reg     <= cfg_wdata[5:0];
                    b2s_pkg::REG_KEY_PART_0: key_part_reg[0] <= cfg_wdata;
                    b2s_pkg::REG_KEY_PART_1: key_part_reg[1] <= cfg_wdata;
                    b2s_pkg::REG_KEY_PART_2: key_part_reg[2] <= cfg_wdata;
                    b2s_pkg::REG_KEY_PART_3: key_part_reg[3] <= cfg_wdata;
                    default:                 out_len_reg     <= out_len_reg;
                endcase
            end

            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if (in_err)
                        begin
                            out_valid_reg <= 1'b1;
                            out_data_reg  <= '{digest_word: 32'h0, word_index: 3'd0,
                                               bytes_valid: 3'd0, last_word: 1'b0,
                                               format_error: 1'b1};
                        end
                        else if (!started_reg)
                        begin
                            for (int i = 1; i < 8; i++)
                            begin
                                cv_reg[i] <= b2s_pkg::IV_TAB[i];
                            end
                            cv_reg[0]   <= b2s_pkg::IV_TAB[0] ^ {8'h01, 8'h01,
                                           2'b00, eff_key_len, 2'b00, eff_out_len};
                            dlen_reg    <= eff_out_len;
                            ctr_reg     <= 64'h0;
                            started_reg <= 1'b1;
                            cnt_reg     <= 5'd0;
                            if (eff_key_len != 6'd0)
                            begin
                                fill_reg  <= 7'(b2s_pkg::BLOCK_BYTES);
                                state_reg <= ST_KEY;
                            end
                            else
                            begin
                                fill_reg  <= 7'd0;
                                state_reg <= ST_CHECK;
                            end
                        end
                        else
                        begin
                            state_reg <= ST_CHECK;
                        end
                    end
                end
                ST_KEY:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd15)
                    begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    if (n_reg == 3'd0)
                    begin
                        cnt_reg   <= 5'(({1'b0, fill_reg} + 8'd3) >> 2);
                        state_reg <= ST_PAD;
                    end
                    else if (fill_reg >= 7'(b2s_pkg::BLOCK_BYTES))
                    begin
                        ctr_reg   <= ctr_reg + 64'(b2s_pkg::BLOCK_BYTES);
                        final_reg <= 1'b0;
                        state_reg <= ST_CINIT;
                    end
                    else
                    begin
                        state_reg <= ST_WRITE;
                    end
                end
                ST_WRITE:
                begin
                    fill_reg <= fill_sum;
                    if (item_reg.last)
                    begin
                        cnt_reg   <= pad_start[4:0];
                        state_reg <= ST_PAD;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_PAD:
                begin
                    if (!cnt_reg[4])
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                    else
                    begin
                        ctr_reg   <= ctr_reg + {57'd0, fill_reg};
                        final_reg <= 1'b1;
                        state_reg <= ST_CINIT;
                    end
                end
                ST_CINIT:
                begin
                    round_reg <= 4'd0;
                    g_reg     <= 3'd0;
                    step_reg  <= 2'd0;
                    state_reg <= ST_ROUND;
                end
                ST_ROUND:
                begin
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'd3)
                    begin
                        g_reg     <= g_nxt;
                        round_reg <= round_nxt;
                        if ((g_reg == 3'd7) && (round_reg == 4'd9))
                        begin
                            state_reg <= ST_CEND;
                        end
                    end
                end
                ST_CEND:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        cv_reg[i] <= cv_reg[i] ^ v_reg[i] ^ v_reg[i + 8];
                    end
                    if (final_reg)
                    begin
                        emit_idx_reg <= 3'd0;
                        state_reg    <= ST_EMIT;
                    end
                    else
                    begin
                        fill_reg  <= 7'd0;
                        state_reg <= ST_WRITE;
                    end
                end
                ST_EMIT:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= '{digest_word: cv_reg[emit_idx_reg]
                                                        & b2s_pkg::byte_mask(emit_valid),
                                           word_index: emit_idx_reg,
                                           bytes_valid: emit_valid,
                                           last_word: (emit_rem <= 7'd4),
                                           format_error: 1'b0};
                        emit_idx_reg  <= emit_idx_reg + 3'd1;
                        if (emit_rem <= 7'd4)
                        begin
                            started_reg <= 1'b0;
                            ctr_reg     <= 64'h0;
                            fill_reg    <= 7'd0;
                            state_reg   <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== tb/blake2s_stream_hash_checker.sv =====
// ----------------------------------------------------------------------------
// blake2s_stream_hash_checker
// watches the input, output and register ports of the hash core, keeps its own
// BLAKE2s model of the core and checks every digest and error transfer against
// the oldest predicted result
// ----------------------------------------------------------------------------
`default_nettype none

module blake2s_stream_hash_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_ready,
    input  wire b2s_pkg::in_item_t   in_data,
    input  wire logic                out_valid,
    input  wire logic                out_ready,
    input  wire b2s_pkg::out_item_t  out_data,
    input  wire logic                cfg_wen,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [63:0]         cfg_wdata,
    output int                       errors,
    output int                       pending
);

    logic [5:0]  out_len_reg;
    logic [5:0]  key_len_reg;
    logic [63:0] key_reg [4];

    logic [31:0] chain [8];
    logic [63:0] msg_bytes;
    logic [31:0] blk [16];
    int          fill;
    bit          started;
    int          dlen;
    logic [31:0] vv [16];

    b2s_pkg::out_item_t digest_q [$];

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] msg_word(input int r, input int p);
        return blk[b2s_pkg::PERM_TAB[r][p]];
    endfunction

    function automatic void mix(input int a, input int b, input int c, input int d,
                                input logic [31:0] x, input logic [31:0] y);
        vv[a] = vv[a] + vv[b] + x;
        vv[d] = rotr(vv[d] ^ vv[a], 16);
        vv[c] = vv[c] + vv[d];
        vv[b] = rotr(vv[b] ^ vv[c], 12);
        vv[a] = vv[a] + vv[b] + y;
        vv[d] = rotr(vv[d] ^ vv[a], 8);
        vv[c] = vv[c] + vv[d];
        vv[b] = rotr(vv[b] ^ vv[c], 7);
    endfunction

    function automatic void compress(input bit fin);
        for (int i = 0; i < 8; i++)
        begin
            vv[i] = chain[i];
            vv[i + 8] = b2s_pkg::IV_TAB[i];
        end
        vv[12] ^= msg_bytes[31:0];
        vv[13] ^= msg_bytes[63:32];
        if (fin)
        begin
            vv[14] = ~vv[14];
        end
        for (int r = 0; r < 10; r++)
        begin
            mix(0, 4, 8, 12, msg_word(r, 0), msg_word(r, 1));
            mix(1, 5, 9, 13, msg_word(r, 2), msg_word(r, 3));
            mix(2, 6, 10, 14, msg_word(r, 4), msg_word(r, 5));
            mix(3, 7, 11, 15, msg_word(r, 6), msg_word(r, 7));
            mix(0, 5, 10, 15, msg_word(r, 8), msg_word(r, 9));
            mix(1, 6, 11, 12, msg_word(r, 10), msg_word(r, 11));
            mix(2, 7, 8, 13, msg_word(r, 12), msg_word(r, 13));
            mix(3, 4, 9, 14, msg_word(r, 14), msg_word(r, 15));
        end
        for (int i = 0; i < 8; i++)
        begin
            chain[i] ^= vv[i] ^ vv[i + 8];
        end
    endfunction

    function automatic void begin_message();
        int kl;
        kl = (key_len_reg > 32) ? 32 : key_len_reg;
        dlen = (out_len_reg == 0) ? 1 : ((out_len_reg > 32) ? 32 : out_len_reg);
        for (int i = 0; i < 8; i++)
        begin
            chain[i] = b2s_pkg::IV_TAB[i];
        end
        chain[0] ^= b2s_pkg::PARAM_BASE | (kl << 8) | dlen;
        msg_bytes = '0;
        fill = 0;
        for (int i = 0; i < 16; i++)
        begin
            blk[i] = '0;
        end
        if (kl > 0)
        begin
            for (int i = 0; i < kl; i++)
            begin
                blk[i >> 2][8 * (i % 4) +: 8] = key_reg[i >> 3][8 * (i % 8) +: 8];
            end
            fill = b2s_pkg::BLOCK_BYTES;
        end
        started = 1'b1;
    endfunction

    function automatic void predict_digest(input b2s_pkg::in_item_t it);
        int                 n;
        int                 words;
        int                 valid;
        logic [31:0]        w;
        b2s_pkg::out_item_t res;
        n = (it.byte_count > 4) ? 4 : it.byte_count;
        if (!it.last && n < 4)
        begin
            res = '0;
            res.format_error = 1'b1;
            digest_q.push_back(res);
            return;
        end
        if (!started)
        begin
            begin_message();
        end
        if (n > 0)
        begin
            if (fill >= b2s_pkg::BLOCK_BYTES)
            begin
                msg_bytes += b2s_pkg::BLOCK_BYTES;
                compress(1'b0);
                fill = 0;
                for (int i = 0; i < 16; i++)
                begin
                    blk[i] = '0;
                end
            end
            w = it.data_word;
            if (n < 4)
            begin
                w &= (32'h1 << (8 * n)) - 1;
            end
            blk[(fill >> 2) & 15] = w;
            fill += n;
        end
        if (!it.last)
        begin
            return;
        end
        for (int i = (fill + 3) >> 2; i < 16; i++)
        begin
            blk[i] = '0;
        end
        msg_bytes += fill;
        compress(1'b1);
        words = (dlen + 3) >> 2;
        for (int i = 0; i < words; i++)
        begin
            valid = (dlen - 4 * i > 4) ? 4 : dlen - 4 * i;
            w = chain[i];
            if (valid < 4)
            begin
                w &= (32'h1 << (8 * valid)) - 1;
            end
            res.digest_word  = w;
            res.word_index   = i[2:0];
            res.bytes_valid  = valid[2:0];
            res.last_word    = (i + 1 == words);
            res.format_error = 1'b0;
            digest_q.push_back(res);
        end
        started = 1'b0;
        msg_bytes = '0;
        fill = 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        b2s_pkg::out_item_t want;
        if (!rst_n)
        begin
            out_len_reg = 6'd32;
            key_len_reg = '0;
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] = '0;
            end
            started = 1'b0;
            fill = 0;
            msg_bytes = '0;
            digest_q.delete();
            errors <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_index)
                    b2s_pkg::REG_OUT_LEN:    out_len_reg = cfg_wdata[5:0];
                    b2s_pkg::REG_KEY_LEN:    key_len_reg = cfg_wdata[5:0];
                    b2s_pkg::REG_KEY_PART_0: key_reg[0] = cfg_wdata;
                    b2s_pkg::REG_KEY_PART_1: key_reg[1] = cfg_wdata;
                    b2s_pkg::REG_KEY_PART_2: key_reg[2] = cfg_wdata;
                    b2s_pkg::REG_KEY_PART_3: key_reg[3] = cfg_wdata;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (digest_q.size() == 0)
                begin
                    if (errors < 10)
                    begin
                        $display("unexpected output transfer: %h", out_data);
                    end
                    errors <= errors + 1;
                end
                else
                begin
                    want = digest_q.pop_front();
                    if (out_data !== want)
                    begin
                        if (errors < 10)
                        begin
                            $display("mismatch: expected word=%h idx=%0d valid=%0d last=%b err=%b",
                                     want.digest_word, want.word_index, want.bytes_valid,
                                     want.last_word, want.format_error);
                            $display("          actual   word=%h idx=%0d valid=%0d last=%b err=%b",
                                     out_data.digest_word, out_data.word_index,
                                     out_data.bytes_valid, out_data.last_word,
                                     out_data.format_error);
                        end
                        errors <= errors + 1;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                predict_digest(in_data);
            end
            pending <= digest_q.size();
        end
    end

endmodule

`default_nettype wire

// ===== tb/blake2s_stream_hash_core_test.sv =====
// ----------------------------------------------------------------------------
// blake2s_stream_hash_core_test
// drives keyed and unkeyed messages, short-word errors and register settings
// into the hash core under random idling on both channels; the checker
// predicts and compares every output transfer
// ----------------------------------------------------------------------------
`default_nettype none

module blake2s_stream_hash_core_test;

    localparam int QUIET_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 800;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    b2s_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_ready;
    b2s_pkg::out_item_t out_data;
    logic               cfg_wen;
    logic [2:0]         cfg_index;
    logic [63:0]        cfg_wdata;
    int                 errors;
    int                 pending;

    int send_idle;
    int recv_idle;
    int stall_len;
    int items_sent;
    int quiet;

    blake2s_stream_hash_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    blake2s_stream_hash_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver side, with one long hold-off whenever stall_len is set
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_len > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall_len) @(posedge clk);
                stall_len = 0;
            end
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial
    begin
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
            if (quiet >= QUIET_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic send_word(input logic [31:0] data, input int cnt, input bit lst);
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data.data_word <= data;
        in_data.byte_count <= cnt[2:0];
        in_data.last <= lst;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // a message of nwords words, the last one carrying tail bytes, plus rejected short words when noisy
    task automatic send_message(input int nwords, input int tail, input bit noisy);
        for (int k = 0; k < nwords - 1; k++)
        begin
            if (noisy && $urandom_range(99) < 8)
            begin
                send_word($urandom, $urandom_range(3), 1'b0);
            end
            send_word($urandom, ($urandom_range(9) == 0) ? $urandom_range(7, 5) : 4, 1'b0);
        end
        send_word($urandom, tail, 1'b1);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wen <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [63:0] ol, input logic [63:0] kl,
                             input logic [63:0] k0, input logic [63:0] k1);
        wait_idle();
        write_reg(b2s_pkg::REG_OUT_LEN, ol);
        write_reg(b2s_pkg::REG_KEY_LEN, kl);
        write_reg(b2s_pkg::REG_KEY_PART_0, k0);
        write_reg(b2s_pkg::REG_KEY_PART_1, k1);
        write_reg(b2s_pkg::REG_KEY_PART_2, {$urandom, $urandom});
        write_reg(b2s_pkg::REG_KEY_PART_3, {$urandom, $urandom});
        write_reg(3'(6 + $urandom_range(1)), {$urandom, $urandom});
    endtask

    task automatic random_config();
        logic [63:0] ol;
        logic [63:0] kl;
        case ($urandom_range(3))
            0: ol = 64'd1;
            1: ol = 64'd32;
            default: ol = {$urandom, $urandom};
        endcase
        case ($urandom_range(3))
            0: kl = 64'd0;
            1: kl = 64'd32;
            default: kl = {$urandom, $urandom};
        endcase
        configure(ol, kl, {$urandom, $urandom}, {$urandom, $urandom});
    endtask

    task automatic random_phase(input int s_idle, input int r_idle, input int budget);
        int goal;
        send_idle = s_idle;
        recv_idle = r_idle;
        goal = items_sent + budget;
        while (items_sent < goal)
        begin
            if ($urandom_range(5) == 0)
            begin
                random_config();
            end
            if ($urandom_range(99) < 85)
            begin
                send_message($urandom_range(1, 12), $urandom_range(7), 1'b1);
            end
            else
            begin
                send_message($urandom_range(14, 40), $urandom_range(7), 1'b1);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_wen = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        send_idle = 0;
        recv_idle = 0;
        stall_len = 0;
        items_sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: empty message, rejected short words, short last words, full-block and two-block messages
        send_word(32'h0, 0, 1'b1);
        for (int c = 0; c < 4; c++)
        begin
            send_word($urandom, c, 1'b0);
        end
        send_word(32'hFFFF_FFFF, 1, 1'b1);
        send_word(32'hFFFF_FFFF, 2, 1'b1);
        send_word(32'h0000_0000, 3, 1'b1);
        send_word(32'hFFFF_FFFF, 7, 1'b1);
        send_message(16, 4, 1'b0);
        send_message(17, 5, 1'b0);

        // extremes of the registers, keyed and unkeyed
        configure(64'd1, 64'd32, '1, '1);
        send_word(32'hFFFF_FFFF, 6, 1'b1);
        send_word(32'h0, 0, 1'b1);
        configure(64'd0, 64'd1, {$urandom, $urandom}, '0);
        send_word($urandom, 4, 1'b1);
        configure(64'd63, 64'd63, '1, '1);
        send_message(3, 2, 1'b0);
        configure(64'd32, 64'd0, '0, '0);
        send_word($urandom, 3, 1'b1);

        random_phase(37, 62, 100);
        random_phase(62, 37, 100);
        random_phase(0, 0, 80);

        // hold the receiver off while short messages pile up
        wait_idle();
        stall_len = 1500;
        for (int k = 0; k < 12; k++)
        begin
            send_message(1, 4, 1'b0);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
